// ===== src/srr_pkg.sv =====
// Shared types, constants and helpers for the selective-repeat receiver.
`timescale 1ns / 1ps
package srr_pkg;

  // Sequence space and window limits
  localparam int SEQ_W      = 3;
  localparam int SEQ_SPACE  = 2 ** SEQ_W;
  localparam int DATA_W     = 64;
  localparam int WIN_W      = 3;
  localparam int MAX_WINDOW = 4;

  // Result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic              checksum_ok;
    logic [SEQ_W-1:0]  seq_num;
    logic [DATA_W-1:0] payload;
  } srr_in_t;

  typedef struct packed {
    logic              out_kind;
    logic [DATA_W-1:0] deliver_data;
    logic [SEQ_W-1:0]  ack_num;
    logic              last;
  } srr_out_t;

  // Window size clamped to 1..MAX_WINDOW and to the sequence space
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
    logic [WIN_W-1:0] w;
    w = ws;
    if (w < WIN_W'(1)) w = WIN_W'(1);
    if (w > WIN_W'(MAX_WINDOW)) w = WIN_W'(MAX_WINDOW);
    if (int'(w) > SEQ_SPACE) w = WIN_W'(SEQ_SPACE);
    return w;
  endfunction

endpackage

// ===== src/srr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/selective_repeat_receiver.sv =====
// Selective-repeat ARQ receiver: window tracking, reorder buffer and delivery.
//
// Input channel (in_valid/in_ready/in_data) takes one packet per request:
// checksum flag, sequence number and a 64-bit payload word. Result channel
// (out_valid/out_ready/out_data) returns deliveries (out_kind 0) followed by
// one acknowledgement (out_kind 1, last set) for each intact packet.
// cfg_we/cfg_wdata write the window size; write only while idle.
// A corrupt packet produces nothing. An ack-only packet (out of window, or
// buffered) goes from idle to the acknowledge state. A packet at the window
// base goes through the head state, the run state for any buffered payloads
// and the acknowledge state, one result per cycle while out_ready allows,
// each buffered payload read from the slot RAM ahead of its delivery. A new
// packet is taken once the ack sits in the output register, even if waiting.
// Reset clears the window base, all slot valid marks and sets the window
// size to 4; slot RAM contents need no clearing. When out_ready is low the
// block holds its current result and stops, and in_ready stays low until
// the pending packet's results have all entered the output register.
`timescale 1ns / 1ps
module selective_repeat_receiver
  import srr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srr_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output srr_out_t         out_data,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_ACK  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [WIN_W-1:0]      win_size_r;
  logic [SEQ_W-1:0]      base_r, base_nxt;
  logic [SEQ_SPACE-1:0]  valid_r, valid_nxt;
  logic [SEQ_W-1:0]      seq_r, seq_nxt;
  logic [DATA_W-1:0]     payload_r, payload_nxt;
  logic [SEQ_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [WIN_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  srr_out_t              out_r, out_nxt;

  logic                  in_fire, out_free;
  logic [WIN_W-1:0]      win;
  logic [SEQ_W-1:0]      offset, next_idx;
  logic [WIN_W-1:0]      cnt_inc;
  logic                  ram_we, ram_re;
  logic [SEQ_W-1:0]      ram_waddr, ram_raddr;
  logic [DATA_W-1:0]     ram_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign win       = eff_window(win_size_r);
  assign offset    = in_data.seq_num - base_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Payload store
  srr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SEQ_SPACE)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data.payload),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequencer: classify, deliver head, drain buffered run, acknowledge
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    valid_nxt     = valid_r;
    seq_nxt       = seq_r;
    payload_nxt   = payload_r;
    rd_idx_nxt    = rd_idx_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = in_data.seq_num;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r;
    next_idx      = rd_idx_r + SEQ_W'(1);
    cnt_inc       = cnt_r + WIN_W'(1);

    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.checksum_ok) begin
          seq_nxt     = in_data.seq_num;
          payload_nxt = in_data.payload;
          if (WIN_W'(offset) >= win) begin
            state_nxt = ST_ACK;
          end else if (in_data.seq_num == base_r) begin
            state_nxt = ST_HEAD;
          end else begin
            ram_we                     = 1'b1;
            valid_nxt[in_data.seq_num] = 1'b1;
            state_nxt                  = ST_ACK;
          end
        end
      end
      ST_HEAD: begin
        next_idx = seq_r + SEQ_W'(1);
        if (out_free) begin
          out_nxt         = '{out_kind: KIND_DELIVER, deliver_data: payload_r,
                              ack_num: '0, last: 1'b0};
          out_valid_nxt   = 1'b1;
          valid_nxt[seq_r] = 1'b0;
          base_nxt        = next_idx;
          if ((WIN_W'(1) < win) && valid_r[next_idx]) begin
            ram_re     = 1'b1;
            ram_raddr  = next_idx;
            rd_idx_nxt = next_idx;
            cnt_nxt    = WIN_W'(1);
            state_nxt  = ST_RUN;
          end else begin
            state_nxt = ST_ACK;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_nxt             = '{out_kind: KIND_DELIVER, deliver_data: ram_rdata,
                                  ack_num: '0, last: 1'b0};
          out_valid_nxt       = 1'b1;
          valid_nxt[rd_idx_r] = 1'b0;
          base_nxt            = next_idx;
          if ((cnt_inc < win) && valid_r[next_idx]) begin
            ram_re     = 1'b1;
            ram_raddr  = next_idx;
            rd_idx_nxt = next_idx;
            cnt_nxt    = cnt_inc;
          end else begin
            state_nxt = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_nxt       = '{out_kind: KIND_ACK, deliver_data: '0,
                            ack_num: seq_r, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      win_size_r  <= WIN_W'(MAX_WINDOW);
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        win_size_r <= cfg_wdata;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    seq_r     <= seq_nxt;
    payload_r <= payload_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cnt_r     <= cnt_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== src/srr_checker.sv =====
// Port-level checks for the selective-repeat receiver, bound to the top level.
`timescale 1ns / 1ps
module srr_checker
  import srr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input srr_in_t          in_data,
  input logic             out_valid,
  input logic             out_ready,
  input srr_out_t         out_data,
  input logic             cfg_we,
  input logic [WIN_W-1:0] cfg_wdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every intact packet closes the input in the cycle after it is taken
  a_busy_after_good: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.checksum_ok |=> !in_ready)
    else $error("input reopened right after an intact packet");

  // The closing result of a packet is always the acknowledgement
  a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.out_kind == KIND_ACK)))
    else $error("last flag does not match acknowledgement");

  // Unused fields are zero on each kind
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_kind == KIND_ACK) ? (out_data.deliver_data == '0)
                                                  : (out_data.ack_num == '0))
    else $error("unused result field not zero");

  // The window size is written only while the block is idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_ready && !out_valid && !$isunknown(cfg_wdata))
    else $error("window size written while busy");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata)
);

// ===== bench/tb.sv =====
// Self-checking bench for the selective-repeat receiver: window tracking, reordering, delivery.
`timescale 1ns / 1ps
module tb
  import srr_pkg::*;
();

  // Stretch of cycles with no request moving on either channel before giving up
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_PACKETS = 56;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  // Tracks the receive window and the results the block still owes
  class arq_rx_tracker;
    logic [WIN_W-1:0]  win_size;
    logic [SEQ_W-1:0]  base_q;
    bit                held [SEQ_SPACE];
    logic [DATA_W-1:0] stash [SEQ_SPACE];
    srr_out_t          owed [$];
    int                errors;

    function new();
      win_size = WIN_W'(MAX_WINDOW);
      base_q   = '0;
      foreach (held[i]) begin
        held[i]  = 1'b0;
        stash[i] = '0;
      end
      errors = 0;
    endfunction

    // Usable window: 0 acts as 1, large values clip to the maximum
    function int span();
      int w;
      w = int'(win_size);
      if (w < 1) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      if (w > SEQ_SPACE) w = SEQ_SPACE;
      return w;
    endfunction

    function void owe_delivery(logic [DATA_W-1:0] d);
      srr_out_t r;
      r.out_kind     = KIND_DELIVER;
      r.deliver_data = d;
      r.ack_num      = '0;
      r.last         = 1'b0;
      owed.push_back(r);
    endfunction

    function void owe_ack(logic [SEQ_W-1:0] seq);
      srr_out_t r;
      r.out_kind     = KIND_ACK;
      r.deliver_data = '0;
      r.ack_num      = seq;
      r.last         = 1'b1;
      owed.push_back(r);
    endfunction

    // Accepted packet: update the window and queue what it produces
    function void note_packet(srr_in_t p);
      logic [SEQ_W-1:0] offs;
      logic [SEQ_W-1:0] s;
      logic [SEQ_W-1:0] pos;
      int               w;
      int               j;
      bit               run;
      if (!p.checksum_ok) return;
      w    = span();
      offs = p.seq_num - base_q;
      if (int'(offs) >= w) begin
        owe_ack(p.seq_num);
        return;
      end
      if (offs == '0) begin
        // in-order packet: deliver it plus any contiguous buffered run
        held[base_q] = 1'b0;
        owe_delivery(p.payload);
        pos = base_q;
        run = 1'b1;
        for (j = 1; j < w && run; j++) begin
          s = base_q + SEQ_W'(j);
          if (held[s]) begin
            owe_delivery(stash[s]);
            held[s] = 1'b0;
            pos     = s;
          end else begin
            run = 1'b0;
          end
        end
        base_q = pos + 1'b1;
      end else begin
        stash[p.seq_num] = p.payload;
        held[p.seq_num]  = 1'b1;
      end
      owe_ack(p.seq_num);
    endfunction

    function void check_result(srr_out_t got);
      srr_out_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: kind %0d data %h ack %0d last %0d",
               got.out_kind, got.deliver_data, got.ack_num, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.out_kind !== want.out_kind) begin
        $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
        errors++;
      end
      if (got.deliver_data !== want.deliver_data) begin
        $error("deliver_data: expected %h, got %h", want.deliver_data, got.deliver_data);
        errors++;
      end
      if (got.ack_num !== want.ack_num) begin
        $error("ack_num: expected %0d, got %0d", want.ack_num, got.ack_num);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  srr_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  srr_out_t         out_data;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;
  int               quiet = 0;

  arq_rx_tracker tracker = new();

  selective_repeat_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // Watchdog on progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result-side backpressure, switching between stall patterns
  initial begin
    rx_mode_e mode;
    int       left;
    int       tick;
    out_ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 80);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_ready <= (tick % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_packet(input srr_in_t p);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    tracker.note_packet(p);
  endtask

  task automatic send_now(input bit ok, input int seq, input logic [DATA_W-1:0] d);
    srr_in_t p;
    p.checksum_ok = ok;
    p.seq_num     = SEQ_W'(seq);
    p.payload     = d;
    send_packet(p);
  endtask

  // Drop valid, wait for every owed result, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.win_size = v;
  endtask

  // Mostly in-window traffic biased toward the base, with noise and corrupt packets
  function automatic srr_in_t pick_packet();
    srr_in_t p;
    int      roll;
    roll          = $urandom_range(0, 99);
    p.payload     = {$urandom, $urandom};
    p.checksum_ok = 1'b1;
    p.seq_num     = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
    if (roll < 8) begin
      p.checksum_ok = 1'b0;
    end else if (roll < 20) begin
      // any sequence number, often outside the window
    end else if (roll < 50) begin
      p.seq_num = tracker.base_q;
    end else begin
      p.seq_num = tracker.base_q + SEQ_W'($urandom_range(0, tracker.span() - 1));
    end
    return p;
  endfunction

  initial begin
    int      plan [8];
    int      ph;
    int      counted;
    int      burst_left;
    int      gap;
    srr_in_t pkt;
    plan      = '{2, 5, 1, 3, 7, 0, 4, 6};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset window of 4
    send_now(0, 0, '1);                          // corrupt, dropped
    send_now(1, 2, '0);                          // buffered
    send_now(1, 2, 64'hFFFF_FFFF_FFFF_FFFF);     // duplicate overwrites slot
    send_now(1, 3, 64'hA5A5_A5A5_5A5A_5A5A);
    send_now(1, 1, 64'h0123_4567_89AB_CDEF);
    send_now(1, 5, 64'h5A5A_0000_FFFF_A5A5);     // past window, ack only
    send_now(1, 0, '1);                          // base: full run of four
    send_now(1, 7, 64'hDEAD_BEEF_CAFE_F00D);     // held across the size change
    send_now(1, 4, 64'h8000_0000_0000_0001);
    send_now(1, 3, 64'h7FFF_FFFF_FFFF_FFFE);     // behind window, ack only
    send_now(0, 7, '0);

    // Shrink to 1 with slot 7 still marked; its mark goes stale at the base
    write_window(1);
    send_now(1, 5, 64'h1111_2222_3333_4444);
    send_now(1, 6, 64'h5555_6666_7777_8888);
    send_now(1, 7, 64'h9999_AAAA_BBBB_CCCC);
    send_now(1, 1, 64'hDDDD_EEEE_FFFF_0000);

    // Zero acts as one
    write_window(0);
    send_now(1, 0, 64'h0F0F_0F0F_0F0F_0F0F);
    send_now(1, 2, 64'hF0F0_F0F0_F0F0_F0F0);

    // Oversized value clips to the maximum
    write_window(7);
    send_now(1, 3, 64'h3333_3333_3333_3333);
    send_now(1, 2, 64'h2222_2222_2222_2222);
    send_now(1, 1, 64'h1111_1111_1111_1111);
    send_now(1, 6, 64'h6666_6666_6666_6666);

    // Random phases, one window setting each
    for (ph = 0; ph < 8; ph++) begin
      write_window(WIN_W'(plan[ph]));
      counted    = 0;
      burst_left = 0;
      while (counted < PHASE_PACKETS) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 4);
          if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
          burst_left = $urandom_range(1, 10);
        end
        pkt = pick_packet();
        send_packet(pkt);
        burst_left--;
        counted++;
      end
    end

    drain_results();
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== selective_repeat_receiver.f =====
src/srr_pkg.sv
src/srr_ram.sv
src/selective_repeat_receiver.sv
src/srr_checker.sv
bench/tb.sv
